### rtl/core/ratalu_pkg.sv
// shared types, codes and the micro-op programs of the rational number alu
package ratalu_pkg;

  localparam int unsigned PcW = 4;

  localparam logic [2:0] OP_ABS = 3'd0;
  localparam logic [2:0] OP_NEG = 3'd1;
  localparam logic [2:0] OP_INV = 3'd2;
  localparam logic [2:0] OP_ADD = 3'd3;
  localparam logic [2:0] OP_SUB = 3'd4;
  localparam logic [2:0] OP_MUL = 3'd5;
  localparam logic [2:0] OP_DIV = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {R_A, R_B, R_C, R_D, R_H, R_K} reg_sel_e;

  typedef enum logic [2:0] {
    U_CHECK, U_UNARY, U_ADDSUB, U_MUL, U_GCD, U_DIV, U_MAKECHK, U_FIX
  } uop_kind_e;

  typedef enum logic [1:0] {CS_IDLE, CS_ISSUE, CS_WAIT, CS_OUT} ctrl_state_e;

  typedef struct packed {
    uop_kind_e kind;
    reg_sel_e  x;
    reg_sel_e  y;
    reg_sel_e  dst;
  } uop_t;

  typedef struct packed {
    logic load;
    logic start;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic fin;
  } dp_stat_t;

  function automatic uop_t mk_uop(uop_kind_e kind, reg_sel_e x, reg_sel_e y, reg_sel_e dst);
    uop_t u;
    u.kind = kind;
    u.x    = x;
    u.y    = y;
    u.dst  = dst;
    return u;
  endfunction

  // normalize h/k: checks, reduce by gcd, fix sign
  function automatic uop_t tail_uop(logic [PcW-1:0] i);
    uop_t u;
    case (i)
      4'd0:    u = mk_uop(U_MAKECHK, R_H, R_K, R_H);
      4'd1:    u = mk_uop(U_GCD, R_H, R_K, R_H);
      4'd2:    u = mk_uop(U_DIV, R_H, R_K, R_H);
      4'd3:    u = mk_uop(U_DIV, R_H, R_K, R_K);
      default: u = mk_uop(U_FIX, R_H, R_K, R_H);
    endcase
    return u;
  endfunction

  function automatic uop_t prog_uop(logic [2:0] op, logic [PcW-1:0] pc);
    uop_t u;
    u = mk_uop(U_FIX, R_H, R_K, R_H);
    if (pc == '0) begin
      u = mk_uop(U_CHECK, R_A, R_B, R_H);
    end else begin
      case (op)
        OP_ABS, OP_NEG, OP_INV: begin
          case (pc)
            4'd1:    u = mk_uop(U_UNARY, R_A, R_B, R_H);
            default: u = tail_uop(pc - 4'd2);
          endcase
        end
        OP_ADD, OP_SUB: begin
          case (pc)
            4'd1:    u = mk_uop(U_MUL, R_A, R_D, R_H);
            4'd2:    u = mk_uop(U_MUL, R_B, R_C, R_K);
            4'd3:    u = mk_uop(U_ADDSUB, R_H, R_K, R_H);
            4'd4:    u = mk_uop(U_MUL, R_B, R_D, R_K);
            default: u = tail_uop(pc - 4'd5);
          endcase
        end
        OP_MUL: begin
          case (pc)
            4'd1:    u = mk_uop(U_GCD, R_A, R_D, R_A);
            4'd2:    u = mk_uop(U_DIV, R_A, R_D, R_A);
            4'd3:    u = mk_uop(U_DIV, R_A, R_D, R_D);
            4'd4:    u = mk_uop(U_GCD, R_B, R_C, R_B);
            4'd5:    u = mk_uop(U_DIV, R_B, R_C, R_B);
            4'd6:    u = mk_uop(U_DIV, R_B, R_C, R_C);
            4'd7:    u = mk_uop(U_MUL, R_A, R_C, R_H);
            4'd8:    u = mk_uop(U_MUL, R_B, R_D, R_K);
            default: u = tail_uop(pc - 4'd9);
          endcase
        end
        OP_DIV: begin
          case (pc)
            4'd1:    u = mk_uop(U_GCD, R_A, R_C, R_A);
            4'd2:    u = mk_uop(U_DIV, R_A, R_C, R_A);
            4'd3:    u = mk_uop(U_DIV, R_A, R_C, R_C);
            4'd4:    u = mk_uop(U_GCD, R_B, R_D, R_B);
            4'd5:    u = mk_uop(U_DIV, R_B, R_D, R_B);
            4'd6:    u = mk_uop(U_DIV, R_B, R_D, R_D);
            4'd7:    u = mk_uop(U_MUL, R_A, R_D, R_H);
            4'd8:    u = mk_uop(U_MUL, R_B, R_C, R_K);
            default: u = tail_uop(pc - 4'd9);
          endcase
        end
        default: u = mk_uop(U_FIX, R_H, R_K, R_H);
      endcase
    end
    return u;
  endfunction

endpackage

### rtl/core/ratalu_gcd.sv
// binary gcd unit, one step per cycle
module ratalu_gcd import ratalu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  input  logic [63:0] y_i,
  output logic        done_o,
  output logic [63:0] g_o
);

  logic [63:0] u_q, u_d, v_q, v_d, g_q, g_d;
  logic [5:0]  sh_q, sh_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q  <= u_d;
    v_q  <= v_d;
    g_q  <= g_d;
    sh_q <= sh_d;
  end

  always_comb begin
    u_d    = u_q;
    v_d    = v_q;
    g_d    = g_q;
    sh_d   = sh_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      u_d    = x_i;
      v_d    = y_i;
      sh_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (u_q == '0 || v_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        g_d    = (u_q | v_q) << sh_q;
        if (u_q == '0 && v_q == '0) begin
          g_d = 64'd1;
        end
      end else if (!u_q[0] && !v_q[0]) begin
        u_d  = u_q >> 1;
        v_d  = v_q >> 1;
        sh_d = sh_q + 6'd1;
      end else if (!u_q[0]) begin
        u_d = u_q >> 1;
      end else if (!v_q[0]) begin
        v_d = v_q >> 1;
      end else if (u_q >= v_q) begin
        u_d = (u_q - v_q) >> 1;
      end else begin
        v_d = (v_q - u_q) >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign g_o    = g_q;

endmodule

### rtl/core/ratalu_div.sv
// restoring divider, one quotient bit per cycle
module ratalu_div import ratalu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] q_o
);

  logic [63:0] q_q, q_d, rem_q, rem_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial, diff;
  logic        fit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign trial = {rem_q, q_q[63]};
  assign diff  = trial - {1'b0, den_q};
  assign fit   = trial >= {1'b0, den_q};

  always_comb begin
    q_d    = q_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      q_d    = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fit ? diff[63:0] : trial[63:0];
      q_d   = {q_q[62:0], fit};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

### rtl/core/ratalu_dp.sv
// datapath: operand registers, checks, shift-add multiplier, gcd and divider units
module ratalu_dp import ratalu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  logic [2:0]         op_i,
  input  logic signed [63:0] a_num_i,
  input  logic [62:0]        a_den_i,
  input  logic signed [63:0] b_num_i,
  input  logic [62:0]        b_den_i,
  output dp_stat_t           stat_o,
  output logic signed [63:0] res_num_o,
  output logic [62:0]        res_den_o,
  output logic [1:0]         status_o
);

  logic [2:0]  op_q, op_d;
  logic [63:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, h_q, h_d, k_q, k_d;
  logic        fin_q, fin_d, done_q, done_d;
  logic [1:0]  st_q, st_d;

  logic [63:0] mhi_q, mhi_d, mlo_q, mlo_d, mcand_q, mcand_d;
  logic [5:0]  mcnt_q, mcnt_d;
  logic        mneg_q, mneg_d, mbusy_q, mbusy_d, mwb_q, mwb_d;
  logic [64:0] msum;
  logic        movf;

  logic        dsign_q, dsign_d;
  logic [63:0] x_val, y_val, dst_val, asum, wval;
  logic        aovf, wen, single;
  logic        gcd_start, gcd_done, div_start, div_done;
  logic [63:0] gcd_g, div_q;

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] pick(reg_sel_e s, logic [63:0] a, logic [63:0] b,
                                       logic [63:0] c, logic [63:0] d,
                                       logic [63:0] h, logic [63:0] k);
    logic [63:0] r;
    case (s)
      R_A:     r = a;
      R_B:     r = b;
      R_C:     r = c;
      R_D:     r = d;
      R_H:     r = h;
      R_K:     r = k;
      default: r = h;
    endcase
    return r;
  endfunction

  assign x_val   = pick(cmd_i.uop.x, a_q, b_q, c_q, d_q, h_q, k_q);
  assign y_val   = pick(cmd_i.uop.y, a_q, b_q, c_q, d_q, h_q, k_q);
  assign dst_val = pick(cmd_i.uop.dst, a_q, b_q, c_q, d_q, h_q, k_q);

  assign gcd_start = cmd_i.start && cmd_i.uop.kind == U_GCD;
  assign div_start = cmd_i.start && cmd_i.uop.kind == U_DIV;
  assign single    = cmd_i.uop.kind != U_GCD && cmd_i.uop.kind != U_DIV
                     && cmd_i.uop.kind != U_MUL;

  ratalu_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (mag64(x_val)),
    .y_i     (mag64(y_val)),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  ratalu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag64(dst_val)),
    .den_i   (gcd_g),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign asum = (op_q == OP_SUB) ? h_q - k_q : h_q + k_q;
  assign aovf = (op_q == OP_SUB) ? (h_q[63] != k_q[63] && asum[63] != h_q[63])
                                 : (h_q[63] == k_q[63] && asum[63] != h_q[63]);

  assign msum = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, mcand_q} : 65'd0);
  assign movf = (mhi_q != '0) || (mlo_q > (mneg_q ? MinVal : MaxVal));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q   <= 1'b0;
      st_q    <= ST_OK;
      done_q  <= 1'b0;
      mbusy_q <= 1'b0;
      mwb_q   <= 1'b0;
      mcnt_q  <= '0;
    end else begin
      fin_q   <= fin_d;
      st_q    <= st_d;
      done_q  <= done_d;
      mbusy_q <= mbusy_d;
      mwb_q   <= mwb_d;
      mcnt_q  <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    d_q     <= d_d;
    h_q     <= h_d;
    k_q     <= k_d;
    mhi_q   <= mhi_d;
    mlo_q   <= mlo_d;
    mcand_q <= mcand_d;
    mneg_q  <= mneg_d;
    dsign_q <= dsign_d;
  end

  always_comb begin
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    h_d     = h_q;
    k_d     = k_q;
    fin_d   = fin_q;
    st_d    = st_q;
    mhi_d   = mhi_q;
    mlo_d   = mlo_q;
    mcand_d = mcand_q;
    mneg_d  = mneg_q;
    mcnt_d  = mcnt_q;
    mbusy_d = mbusy_q;
    mwb_d   = 1'b0;
    dsign_d = dsign_q;
    wen     = 1'b0;
    wval    = '0;
    done_d  = (cmd_i.start && single) || gcd_done || div_done || mwb_q;

    if (cmd_i.load) begin
      op_d  = op_i;
      a_d   = a_num_i;
      b_d   = {1'b0, a_den_i};
      c_d   = b_num_i;
      d_d   = {1'b0, b_den_i};
      h_d   = '0;
      k_d   = '0;
      fin_d = 1'b0;
      st_d  = ST_OK;
    end else if (cmd_i.start) begin
      case (cmd_i.uop.kind)
        U_CHECK: begin
          if (op_q > OP_DIV || a_q == MinVal) begin
            fin_d = 1'b1;
            st_d  = ST_OVF;
          end else if (b_q == '0) begin
            fin_d = 1'b1;
            st_d  = ST_DIV0;
          end else if (op_q >= OP_ADD && c_q == MinVal) begin
            fin_d = 1'b1;
            st_d  = ST_OVF;
          end else if ((op_q >= OP_ADD && d_q == '0) || (op_q == OP_INV && a_q == '0)
                       || (op_q == OP_DIV && c_q == '0)) begin
            fin_d = 1'b1;
            st_d  = ST_DIV0;
          end else if (op_q == OP_DIV && a_q == '0) begin
            fin_d = 1'b1;
            h_d   = '0;
            k_d   = 64'd1;
          end
        end
        U_UNARY: begin
          case (op_q)
            OP_ABS: begin
              h_d = mag64(a_q);
              k_d = b_q;
            end
            OP_NEG: begin
              h_d = -a_q;
              k_d = b_q;
            end
            default: begin
              h_d = a_q[63] ? -b_q : b_q;
              k_d = mag64(a_q);
            end
          endcase
        end
        U_ADDSUB: begin
          if (aovf) begin
            fin_d = 1'b1;
            st_d  = ST_OVF;
          end else begin
            h_d = asum;
          end
        end
        U_MUL: begin
          mcand_d = mag64(y_val);
          mlo_d   = mag64(x_val);
          mhi_d   = '0;
          mneg_d  = x_val[63] ^ y_val[63];
          mcnt_d  = '0;
          mbusy_d = 1'b1;
        end
        U_DIV: dsign_d = dst_val[63];
        U_MAKECHK: begin
          if (h_q == MinVal || k_q == MinVal) begin
            fin_d = 1'b1;
            st_d  = ST_OVF;
          end else if (k_q == '0) begin
            fin_d = 1'b1;
            st_d  = ST_DIV0;
          end else if (h_q == '0) begin
            fin_d = 1'b1;
            k_d   = 64'd1;
          end
        end
        U_FIX: begin
          fin_d = 1'b1;
          if (k_q[63]) begin
            h_d = -h_q;
            k_d = -k_q;
          end
        end
        default: fin_d = fin_q;
      endcase
    end

    if (mbusy_q) begin
      mhi_d  = msum[64:1];
      mlo_d  = {msum[0], mlo_q[63:1]};
      mcnt_d = mcnt_q + 6'd1;
      if (mcnt_q == 6'd63) begin
        mbusy_d = 1'b0;
        mwb_d   = 1'b1;
      end
    end

    if (mwb_q) begin
      if (movf) begin
        fin_d = 1'b1;
        st_d  = ST_OVF;
      end else begin
        wen  = 1'b1;
        wval = mneg_q ? -mlo_q : mlo_q;
      end
    end

    if (div_done) begin
      wen  = 1'b1;
      wval = dsign_q ? -div_q : div_q;
    end

    if (wen) begin
      case (cmd_i.uop.dst)
        R_A:     a_d = wval;
        R_B:     b_d = wval;
        R_C:     c_d = wval;
        R_D:     d_d = wval;
        R_H:     h_d = wval;
        R_K:     k_d = wval;
        default: h_d = wval;
      endcase
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.fin  = fin_q;
  assign res_num_o   = (st_q == ST_OK) ? h_q : '0;
  assign res_den_o   = (st_q == ST_OK) ? k_q[62:0] : '0;
  assign status_o    = st_q;

endmodule

### rtl/core/ratalu_ctrl.sv
// controller: steps through the micro-op program of the current op
module ratalu_ctrl import ratalu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] op_i,
  input  logic       out_free_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o,
  output logic       in_stall_o,
  output logic       out_load_o
);

  ctrl_state_e    state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [2:0]     op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      pc_q    <= '0;
      op_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    op_d        = op_q;
    cmd_o.load  = 1'b0;
    cmd_o.start = 1'b0;
    cmd_o.uop   = prog_uop(op_q, pc_q);
    in_stall_o  = 1'b1;
    out_load_o  = 1'b0;
    case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = op_i;
          pc_d       = '0;
          state_d    = CS_ISSUE;
        end
      end
      CS_ISSUE: begin
        cmd_o.start = 1'b1;
        state_d     = CS_WAIT;
      end
      CS_WAIT: begin
        if (stat_i.done) begin
          if (stat_i.fin) begin
            state_d = CS_OUT;
          end else begin
            pc_d    = pc_q + 1'b1;
            state_d = CS_ISSUE;
          end
        end
      end
      CS_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule

### rtl/core/rational_number_alu.sv
// top level of the rational number alu
//
// Takes one item (op code and two reduced rationals a_num/a_den and b_num/b_den)
// on the input channel and returns one reduced rational with a status on the
// output channel. Both channels move an item at a clock edge where valid is
// high and stall is low.
// A controller walks a short micro-op program per op code; the datapath runs
// each micro-op on a binary gcd unit (one step per cycle), a restoring
// divider and a shift-add multiplier. One item is worked on at a time.
// in_stall_o is low only while the block is idle; the result sits in an
// output register, so a new item is taken while an earlier result still
// waits on a stalled receiver. The result register is held until taken.
// Reset clears the controller and the output valid; no item is in flight.
module rational_number_alu import ratalu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic signed [63:0] a_num_i,
  input  logic [62:0]        a_den_i,
  input  logic signed [63:0] b_num_i,
  input  logic [62:0]        b_den_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] res_num_o,
  output logic [62:0]        res_den_o,
  output logic [1:0]         status_o
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic               out_load, out_free;
  logic               out_valid_q, out_valid_d;
  logic signed [63:0] dp_num, res_num_q;
  logic [62:0]        dp_den, res_den_q;
  logic [1:0]         dp_status, status_q;

  assign out_free = !out_valid_q || !out_stall_i;

  ratalu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_load_o (out_load)
  );

  ratalu_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .op_i      (op_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .stat_o    (stat),
    .res_num_o (dp_num),
    .res_den_o (dp_den),
    .status_o  (dp_status)
  );

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_num_q <= dp_num;
      res_den_q <= dp_den;
      status_q  <= dp_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign status_o    = status_q;

endmodule

### rtl/core/ratalu_checker.sv
// port-level checks on the rational number alu, bound to the top level
module ratalu_checker import ratalu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [63:0] res_num_o,
  input logic [62:0]        res_den_o,
  input logic [1:0]         status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> res_num_o == '0 && res_den_o == '0)
    else $error("error result not zeroed");

  a_zero_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK && res_num_o == '0 |-> res_den_o == 63'd1)
    else $error("zero result not 0/1");

endmodule

bind rational_number_alu ratalu_checker u_ratalu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .res_num_o   (res_num_o),
  .res_den_o   (res_den_o),
  .status_o    (status_o)
);

### tb/tb_rational_number_alu.sv
// testbench of the rational number alu: directed table, then random items checked by a predictor
`timescale 1ns / 1ps

module tb_rational_number_alu;
  import ratalu_pkg::*;

  typedef struct packed {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic [1:0]         st;
  } ratio_t;

  typedef struct {
    logic [2:0]  op;
    longint      an;
    logic [62:0] ad;
    longint      bn;
    logic [62:0] bd;
    bit          typed;
    ratio_t      res;
  } row_t;

  localparam longint Lmin = longint'(MinVal);
  localparam longint Lmax = longint'(MaxVal);
  localparam logic [62:0] DenMax = MaxVal[62:0];
  localparam int WatchLimit = 20000;
  localparam int NumRandom = 1400;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         op_i;
  logic signed [63:0] a_num_i;
  logic [62:0]        a_den_i;
  logic signed [63:0] b_num_i;
  logic [62:0]        b_den_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [63:0] res_num_o;
  logic [62:0]        res_den_o;
  logic [1:0]         status_o;

  ratio_t pending_q[$];
  int     errors;
  int     send_pct;
  int     recv_pct;
  int     results_seen;
  int     hold_left;
  bit     hold_done;
  int     quiet_cycles;

  rational_number_alu uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .a_num_i, .a_den_i,
    .b_num_i, .b_den_i, .out_valid_o, .out_stall_i, .res_num_o, .res_den_o, .status_o
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [63:0] magn(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint signed_of(logic [63:0] m, bit neg);
    return neg ? longint'(-m) : longint'(m);
  endfunction

  function automatic logic [63:0] gcd_mag(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic [63:0] gcd_nz(longint x, longint y);
    logic [63:0] g;
    g = gcd_mag(magn(x), magn(y));
    return g == 0 ? 64'd1 : g;
  endfunction

  function automatic longint div_mag(longint x, logic [63:0] g);
    return signed_of(magn(x) / g, x < 0);
  endfunction

  function automatic bit mul_ok(longint x, longint y, output longint r);
    logic [127:0] p;
    bit neg;
    neg = (x < 0) != (y < 0);
    r = 0;
    if (x == 0 || y == 0) return 1;
    p = magn(x) * magn(y);
    if (p > (neg ? 128'(MinVal) : 128'(MaxVal))) return 0;
    r = signed_of(p[63:0], neg);
    return 1;
  endfunction

  function automatic ratio_t normalize(longint h, longint k);
    ratio_t r;
    logic [63:0] g;
    r = '0;
    if (h == Lmin || k == Lmin) r.st = ST_OVF;
    else if (k == 0) r.st = ST_DIV0;
    else if (h == 0) r.den = 63'd1;
    else begin
      g = gcd_mag(magn(h), magn(k));
      h = div_mag(h, g);
      k = div_mag(k, g);
      if (k < 0) begin
        h = -h;
        k = -k;
      end
      r.num = h;
      r.den = k[62:0];
    end
    return r;
  endfunction

  function automatic ratio_t predict_ratio(logic [2:0] op, longint an, logic [62:0] ad,
                                           longint bn, logic [62:0] bd);
    ratio_t r;
    longint a, b, c, d, h, k, t1, t2;
    logic [63:0] g;
    r = '0;
    a = an;
    b = longint'({1'b0, ad});
    c = bn;
    d = longint'({1'b0, bd});
    if (op > OP_DIV || a == Lmin) begin
      r.st = ST_OVF;
      return r;
    end
    if (b == 0) begin
      r.st = ST_DIV0;
      return r;
    end
    if (op >= OP_ADD) begin
      if (c == Lmin) begin
        r.st = ST_OVF;
        return r;
      end
      if (d == 0) begin
        r.st = ST_DIV0;
        return r;
      end
    end
    case (op)
      OP_ABS: return normalize(a < 0 ? -a : a, b);
      OP_NEG: return normalize(-a, b);
      OP_INV: begin
        if (a == 0) begin
          r.st = ST_DIV0;
          return r;
        end
        return a > 0 ? normalize(b, a) : normalize(-b, -a);
      end
      OP_ADD, OP_SUB: begin
        if (!mul_ok(a, d, t1) || !mul_ok(b, c, t2)) begin
          r.st = ST_OVF;
          return r;
        end
        h = op == OP_ADD ? t1 + t2 : t1 - t2;
        if ((op == OP_ADD && (t1 < 0) == (t2 < 0) && (h < 0) != (t1 < 0)) ||
            (op == OP_SUB && (t1 < 0) != (t2 < 0) && (h < 0) != (t1 < 0)) ||
            !mul_ok(b, d, k)) begin
          r.st = ST_OVF;
          return r;
        end
        return normalize(h, k);
      end
      OP_MUL: begin
        g = gcd_nz(a, d); a = div_mag(a, g); d = div_mag(d, g);
        g = gcd_nz(b, c); b = div_mag(b, g); c = div_mag(c, g);
        if (!mul_ok(a, c, h) || !mul_ok(b, d, k)) begin
          r.st = ST_OVF;
          return r;
        end
        return normalize(h, k);
      end
      default: begin
        if (c == 0) begin
          r.st = ST_DIV0;
          return r;
        end
        if (a == 0) return normalize(0, 1);
        g = gcd_nz(a, c); a = div_mag(a, g); c = div_mag(c, g);
        g = gcd_nz(b, d); b = div_mag(b, g); d = div_mag(d, g);
        if (!mul_ok(a, d, h) || !mul_ok(b, c, k)) begin
          r.st = ST_OVF;
          return r;
        end
        return normalize(h, k);
      end
    endcase
  endfunction

  function automatic longint rand_num();
    longint v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = longint'($urandom_range(0, 100)) - 50;
      4, 5:       v = longint'($urandom_range(0, 65535)) - 32768;
      6, 7:       v = longint'(int'($urandom));
      8:          v = {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 4))
          0:       v = Lmax;
          1:       v = -Lmax;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
    endcase
    if ($urandom_range(0, 99) < 2) v = Lmin;
    return v;
  endfunction

  function automatic logic [62:0] rand_den();
    logic [62:0] v;
    logic [63:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 63'($urandom_range(1, 50));
      4, 5:       v = 63'($urandom_range(1, 65535));
      6, 7:       v = 63'($urandom);
      8: begin
        w = {$urandom, $urandom};
        v = w[62:0];
      end
      default:    v = $urandom_range(0, 1) ? DenMax : 63'd1;
    endcase
    if ($urandom_range(0, 99) < 3) v = '0;
    return v;
  endfunction

  task automatic drive_item(logic [2:0] op, longint an, logic [62:0] ad, longint bn,
                            logic [62:0] bd, bit typed, ratio_t typed_res);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    op_i <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(typed ? typed_res : predict_ratio(op, an, ad, bn, bd));
  endtask

  task automatic random_item();
    logic [2:0] op;
    longint an, bn;
    logic [62:0] ad, bd;
    logic [63:0] g;
    op = $urandom_range(0, 99) < 2 ? 3'd7 : 3'($urandom_range(0, 6));
    an = rand_num();
    ad = rand_den();
    bn = rand_num();
    bd = rand_den();
    if ($urandom_range(0, 3) != 0 && an != Lmin && ad != 0) begin
      g = gcd_mag(magn(an), 64'(ad));
      an = div_mag(an, g);
      ad = 63'(64'(ad) / g);
    end
    if ($urandom_range(0, 3) != 0 && bn != Lmin && bd != 0) begin
      g = gcd_mag(magn(bn), 64'(bd));
      bn = div_mag(bn, g);
      bd = 63'(64'(bd) / g);
    end
    drive_item(op, an, ad, bn, bd, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_seen == 60) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(0, 99) < recv_pct;
    end
  end

  always @(posedge clk_i) begin
    ratio_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item num %0d den %0d status %0d",
                 $time, res_num_o, res_den_o, status_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (res_num_o !== want.num) begin
          $display("%0t: res_num expected %0d actual %0d", $time, want.num, res_num_o);
          errors++;
        end
        if (res_den_o !== want.den) begin
          $display("%0t: res_den expected %0d actual %0d", $time, want.den, res_den_o);
          errors++;
        end
        if (status_o !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("tb_rational_number_alu NOT OK");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int drain;
    errors = 0;
    results_seen = 0;
    hold_left = 0;
    hold_done = 1'b0;
    quiet_cycles = 0;
    send_pct = 34;
    recv_pct = 70;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    op_i = OP_ABS;
    a_num_i = '0;
    a_den_i = '0;
    b_num_i = '0;
    b_den_i = '0;
    rows = '{
      '{OP_ABS, -5, 3, 0, 1, 1, '{64'sd5, 63'd3, ST_OK}},
      '{OP_NEG, 7, 2, 0, 1, 1, '{-64'sd7, 63'd2, ST_OK}},
      '{OP_INV, -3, 4, 0, 1, 1, '{-64'sd4, 63'd3, ST_OK}},
      '{OP_INV, 0, 1, 0, 1, 1, '{64'sd0, 63'd0, ST_DIV0}},
      '{OP_ADD, 1, 2, 1, 3, 1, '{64'sd5, 63'd6, ST_OK}},
      '{OP_SUB, 1, 2, 1, 2, 1, '{64'sd0, 63'd1, ST_OK}},
      '{OP_MUL, 2, 3, 3, 4, 1, '{64'sd1, 63'd2, ST_OK}},
      '{OP_DIV, 0, 1, 5, 7, 1, '{64'sd0, 63'd1, ST_OK}},
      '{OP_DIV, 1, 1, 0, 1, 1, '{64'sd0, 63'd0, ST_DIV0}},
      '{OP_DIV, 0, 1, 0, 1, 1, '{64'sd0, 63'd0, ST_DIV0}},
      '{3'd7, 1, 1, 1, 1, 1, '{64'sd0, 63'd0, ST_OVF}},
      '{OP_ADD, Lmin, 1, 1, 1, 1, '{64'sd0, 63'd0, ST_OVF}},
      '{OP_NEG, 1, 0, 1, 1, 1, '{64'sd0, 63'd0, ST_DIV0}},
      '{OP_ABS, Lmin, 0, 1, 1, 1, '{64'sd0, 63'd0, ST_OVF}},
      '{OP_ADD, 1, 1, Lmin, 1, 1, '{64'sd0, 63'd0, ST_OVF}},
      '{OP_ABS, 3, 1, Lmin, 0, 1, '{64'sd3, 63'd1, ST_OK}},
      '{OP_SUB, 1, 1, 1, 0, 1, '{64'sd0, 63'd0, ST_DIV0}},
      '{OP_MUL, Lmax, 1, 2, 1, 1, '{64'sd0, 63'd0, ST_OVF}},
      '{OP_ADD, Lmax, 1, 1, 1, 1, '{64'sd0, 63'd0, ST_OVF}},
      '{OP_ABS, Lmax, DenMax, 0, 1, 1, '{64'sd1, 63'd1, ST_OK}},
      '{OP_NEG, -Lmax, 1, 0, 1, 1, '{Lmax, 63'd1, ST_OK}},
      '{OP_ABS, 4, 6, 0, 1, 1, '{64'sd2, 63'd3, ST_OK}},
      '{OP_SUB, -Lmax, 1, 1, 1, 1, '{64'sd0, 63'd0, ST_OVF}},
      '{OP_MUL, -Lmax, 1, Lmax, DenMax, 0, '0},
      '{OP_DIV, -6, 35, 4, 15, 0, '0}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i])
      drive_item(rows[i].op, rows[i].an, rows[i].ad, rows[i].bn, rows[i].bd,
                 rows[i].typed, rows[i].res);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) begin
        send_pct = 70;
        recv_pct = 34;
      end else if (n == 2 * NumRandom / 3) begin
        send_pct = 0;
        recv_pct = 0;
      end
      random_item();
    end
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 1200) begin
      @(posedge clk_i);
      drain++;
    end
    if (errors == 0) $display("tb_rational_number_alu OK");
    else $display("tb_rational_number_alu NOT OK");
    $finish;
  end

endmodule
